@@ hdl/moving_average_settle_detector_top_macros.svh @@
// Assertion macros for the moving-average settle detector.
// Each expects clk and rst to be visible where it is used.
`ifndef MOVING_AVERAGE_SETTLE_DETECTOR_TOP_MACROS_SVH
`define MOVING_AVERAGE_SETTLE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication.
`define MASD_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MASD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/masd_pkg.sv @@
`default_nettype none

package masd_pkg;

  localparam int WINDOW_LEN = 16;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN) + 1;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
  localparam int CNT_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int DIFF_W     = SAMPLE_W + 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [FILL_W-1:0]          fill_t;

  // Configuration register indexes
  typedef enum logic {
    REG_TARGET    = 1'b0,
    REG_DEV_LIMIT = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

@@ hdl/masd_cell.sv @@
`default_nettype none

module masd_cell (
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire masd_pkg::sample_t din,
  output masd_pkg::sample_t      dout
);
  import masd_pkg::*;

  // Window storage: take the neighbour's sample on each shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

@@ hdl/masd_div.sv @@
`default_nettype none

module masd_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire masd_pkg::sum_t    dividend,
  input  wire masd_pkg::fill_t   divisor,
  output logic                   done,
  output masd_pkg::sample_t      quotient
);
  import masd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FILL_W-1:0]    rem;
  logic [SUM_W-1:0]     quo;
  logic                 neg;
  fill_t                dvs;

  logic [FILL_W:0]      trial;
  logic [FILL_W:0]      trial_sub;
  logic                 fits;
  logic [FILL_W-1:0]    rem_next;
  logic [SUM_W-1:0]     magnitude;
  logic [SUM_W-1:0]     signed_quo;

  // Restoring division, one quotient bit a cycle, on the magnitude.
  assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial     = {rem, quo[SUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = (trial >= {1'b0, dvs});
  assign rem_next  = fits ? trial_sub[FILL_W-1:0] : trial[FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= magnitude;
      neg <= dividend[SUM_W-1];
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  // Restore the sign: truncation toward zero.
  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = sample_t'(signed_quo[SAMPLE_W-1:0]);

endmodule

`default_nettype wire

@@ hdl/moving_average_settle_detector_top.sv @@
`default_nettype none

// Moving-average settle detector. Each accepted sample enters a window of the
// last WINDOW_LEN (16) samples and produces one result: the window mean,
// truncated toward zero (divided by the number of samples held while the
// window fills), a settled flag (window full and both the true window maximum
// and minimum lie within the deviation limit of the mean) and an on-target
// flag (mean within the deviation limit of target). One sample occupies the
// block until its result is presented: the bit-serial divider works through
// every bit of the 21-bit running sum, the sequencer notices completion and
// the output register is loaded, while the window is rotated once through its
// row of cells to find maximum and minimum in parallel. in_ready returns high
// in the same cycle as the result is presented. in_ready is high only while no
// sample is in work and is held low in reset; a finished result waits in the
// output register and does not hold off the next sample, but if it is still
// waiting when the next result is ready, that result holds in_ready low until
// the transfer out.
// The window has no reset and needs no clearing pass: its contents are used
// only once all entries have been written. Write target and the deviation
// limit only while the block is idle.

module moving_average_settle_detector_top (
  input  wire logic              clk,
  input  wire logic              rst,
  // sample channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire masd_pkg::sample_t sample,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output masd_pkg::sample_t      mean,
  output logic                   settled,
  output logic                   on_target,
  // configuration
  input  wire logic              wr_en,
  input  wire logic              wr_index,
  input  wire logic [15:0]       wr_data
);
  import masd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration
  sample_t     target;
  logic [15:0] dev_limit;

  // Window bookkeeping
  sum_t       sum;
  sum_t       sum_next;
  fill_t      fill;
  fill_t      fill_next;
  logic       full_now;
  logic       full_q;
  logic [CNT_W-1:0] scan_cnt;
  sample_t    win_max;
  sample_t    win_min;

  // Cell row
  sample_t    chain [WINDOW_LEN];
  sample_t    tail;
  sample_t    head_in;
  logic       shift;
  logic       accept;

  // Divider
  logic       div_done;
  sample_t    div_mean;

  // Flag compare
  logic signed [DIFF_W-1:0] lim_x;
  logic signed [DIFF_W-1:0] d_hi;
  logic signed [DIFF_W-1:0] d_lo;
  logic signed [DIFF_W-1:0] d_tgt;
  logic signed [DIFF_W-1:0] d_tgt_neg;
  logic       settled_c;
  logic       on_target_c;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      dev_limit <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_TARGET:    target    <= sample_t'(wr_data);
        REG_DEV_LIMIT: dev_limit <= wr_data;
      endcase
    end
  end

  // Row of cells: a new sample enters at the head on transfer, the oldest
  // drops out of the tail. During the scan the row rotates once, tail back
  // to head, so after WINDOW_LEN steps the order is restored.
  assign tail    = chain[WINDOW_LEN-1];
  assign shift   = accept || (state == S_SCAN);
  assign head_in = (state == S_IDLE) ? sample : tail;

  masd_cell u_cell_head (
    .clk   (clk),
    .shift (shift),
    .din   (head_in),
    .dout  (chain[0])
  );

  for (genvar i = 1; i < WINDOW_LEN; i++) begin : g_cell
    masd_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .din   (chain[i-1]),
      .dout  (chain[i])
    );
  end

  // Running sum: add the new sample, drop the oldest once the window is full.
  assign full_now  = (fill == FILL_W'(WINDOW_LEN));
  assign fill_next = full_now ? fill : fill + 1'b1;
  assign sum_next  = sum + sum_t'(sample) - (full_now ? sum_t'(tail) : sum_t'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      fill   <= '0;
      full_q <= 1'b0;
    end else if (accept) begin
      sum    <= sum_next;
      fill   <= fill_next;
      full_q <= (fill_next == FILL_W'(WINDOW_LEN));
    end
  end

  // Mean: sum over samples held, started on the transfer cycle.
  masd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (sum_next),
    .divisor  (fill_next),
    .done     (div_done),
    .quotient (div_mean)
  );

  // Max and min over the tail as the row rotates.
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      if (scan_cnt == '0) begin
        win_max <= tail;
        win_min <= tail;
      end else begin
        if (tail > win_max) begin
          win_max <= tail;
        end
        if (tail < win_min) begin
          win_min <= tail;
        end
      end
    end
  end

  // Flags, both against the truncated mean. |d| <= lim as d <= lim and -d <= lim.
  assign lim_x       = DIFF_W'(signed'({1'b0, dev_limit}));
  assign d_hi        = DIFF_W'(win_max) - DIFF_W'(div_mean);
  assign d_lo        = DIFF_W'(div_mean) - DIFF_W'(win_min);
  assign d_tgt       = DIFF_W'(div_mean) - DIFF_W'(target);
  assign d_tgt_neg   = -d_tgt;
  assign settled_c   = full_q && (d_hi <= lim_x) && (d_lo <= lim_x);
  assign on_target_c = (d_tgt <= lim_x) && (d_tgt_neg <= lim_x);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a finished result once the register is free, else drop valid
      // after the transfer out.
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        mean      <= div_mean;
        settled   <= settled_c;
        on_target <= on_target_c;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == CNT_W'(WINDOW_LEN - 1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the previous result has been taken.
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/masd_checker.sv @@
`default_nettype none

`include "moving_average_settle_detector_top_macros.svh"

module masd_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire masd_pkg::sample_t mean,
  input wire logic              settled,
  input wire logic              on_target
);
  import masd_pkg::*;

  logic        stall;
  logic        in_xfer;
  logic [17:0] res_bits;

  assign stall    = out_valid && !out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign res_bits = {mean, settled, on_target};

  `MASD_NEXT(a_out_hold, stall, out_valid && $stable(res_bits), "result moved while stalled")

  `MASD_NEXT(a_busy_after_in, in_xfer, !in_ready, "sample accepted while one is in work")

  `MASD_NEXT(a_no_instant_out, in_xfer, !$rose(out_valid), "result right after sample transfer")

endmodule

bind moving_average_settle_detector_top masd_checker u_masd_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Checks the moving-average settle detector: a table of directed rows, then
// random phases, each with its own target and error limit. Every result is
// compared field by field against a predictor that keeps its own copy of the
// window, fill count and running sum, or against the row's own typed result.

module testbench;
  import masd_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 40;   // comfortably above the latency of one sample
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int DIR_ROWS        = 12;

  typedef struct {
    sample_t mean;
    logic    settled;
    logic    on_target;
  } avg_result_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_TARGET,
    ROW_LIMIT
  } row_kind_t;

  // One row of the directed table. Sample rows may repeat; where typed is set
  // the expected result is the one written in the row.
  typedef struct {
    row_kind_t   kind;
    logic [15:0] value;
    int          reps;
    bit          typed;
    sample_t     mean;
    logic        settled;
    logic        on_target;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  sample_t     sample;
  logic        out_valid;
  logic        out_ready;
  sample_t     mean;
  logic        settled;
  logic        on_target;
  logic        wr_en;
  logic        wr_index;
  logic [15:0] wr_data;

  // Predictor state: window ring, write position, fill count, running sum
  sample_t          win_ring [WINDOW_LEN];
  logic [CNT_W-1:0] ring_pos;
  fill_t            ring_fill;
  sum_t             ring_sum;
  sample_t          cfg_target;
  logic [15:0]      cfg_limit;

  avg_result_t expected_averages [$];
  avg_result_t head_result;
  stim_row_t   dir_rows [DIR_ROWS];

  int  errors;
  int  cycle_count;
  int  samples_sent;
  int  results_checked;
  int  settled_seen;
  int  on_target_seen;
  bit  burst;
  int  ready_hold;

  moving_average_settle_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mean      (mean),
    .settled   (settled),
    .on_target (on_target),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the window by one sample and work out the result it gives.
  function automatic avg_result_t predict_average(input sample_t s);
    avg_result_t r;
    int m;
    int lim;
    int mx;
    int mn;
    int dev;
    if (ring_fill < WINDOW_LEN) begin
      ring_sum  = ring_sum + s;
      ring_fill = ring_fill + 1'b1;
    end else begin
      ring_sum = ring_sum + s - win_ring[ring_pos];
    end
    win_ring[ring_pos] = s;
    ring_pos = (ring_pos == CNT_W'(WINDOW_LEN - 1)) ? '0 : ring_pos + 1'b1;

    // int division truncates toward zero, as the block does
    m   = int'(ring_sum) / int'(ring_fill);
    lim = int'(cfg_limit);
    r.mean    = sample_t'(m);
    r.settled = 1'b0;
    // the spread is only looked at once every entry has been written
    if (ring_fill == WINDOW_LEN) begin
      mx = win_ring[0];
      mn = win_ring[0];
      for (int i = 1; i < WINDOW_LEN; i++) begin
        if (win_ring[i] > mx) mx = win_ring[i];
        if (win_ring[i] < mn) mn = win_ring[i];
      end
      r.settled = (mx - m <= lim) && (m - mn <= lim);
    end
    dev = m - int'(cfg_target);
    if (dev < 0) dev = -dev;
    r.on_target = (dev <= lim);
    return r;
  endfunction

  // Back-to-back in a burst; else mostly so, or a short gap, or rarely a long pause.
  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // Random sample: mostly around the phase level, some full-range noise and
  // some extremes; a noisy phase turns the mix around.
  function automatic sample_t make_sample(input int level, input int spread, input bit noisy);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < (noisy ? 80 : 8)) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else if (r < (noisy ? 90 : 13)) begin
      case ($urandom_range(0, 3))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = -1;
        default: v = 0;
      endcase
    end else begin
      v = level + int'($urandom_range(0, 2 * spread)) - spread;
    end
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d: %s got %0d, expected %0d", results_checked, what, got, want);
    errors++;
  endtask

  // Offer one sample, hold it until the transfer, then record what it should give.
  task automatic send_sample(input sample_t s, input bit typed, input avg_result_t typed_res);
    int gap;
    avg_result_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = s;
    do @(posedge clk); while (!in_ready);
    r = predict_average(s);
    if (typed) r = typed_res;
    expected_averages.push_back(r);
    samples_sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let the block go quiet.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      REG_TARGET:    cfg_target = sample_t'(data);
      REG_DEV_LIMIT: cfg_limit  = data;
      default:       ;
    endcase
  endtask

  // Receiver: alternate ready stretches with stalls of random length; in a
  // burst phase keep ready high throughout.
  initial begin
    out_ready  = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (out_ready && !burst) begin
        out_ready  = 1'b0;
        ready_hold = pick_gap();
      end else begin
        out_ready  = 1'b1;
        ready_hold = $urandom_range(0, 8);
      end
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        report_mismatch("result with nothing outstanding, mean", int'(mean), 0);
      end else begin
        head_result = expected_averages.pop_front();
        if (mean !== head_result.mean)
          report_mismatch("mean", int'(mean), int'(head_result.mean));
        if (settled !== head_result.settled)
          report_mismatch("settled", int'(settled), int'(head_result.settled));
        if (on_target !== head_result.on_target)
          report_mismatch("on_target", int'(on_target), int'(head_result.on_target));
        if (head_result.settled)   settled_seen++;
        if (head_result.on_target) on_target_seen++;
      end
      results_checked++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_averages.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int          level;
    int          spread;
    int          offset;
    bit          noisy;
    logic [15:0] tgt;
    logic [15:0] lim;
    avg_result_t typed_res;

    errors          = 0;
    cycle_count     = 0;
    samples_sent    = 0;
    results_checked = 0;
    settled_seen    = 0;
    on_target_seen  = 0;
    burst           = 1'b0;
    ring_pos        = '0;
    ring_fill       = '0;
    ring_sum        = '0;
    cfg_target      = '0;
    cfg_limit       = '0;
    for (int i = 0; i < WINDOW_LEN; i++) win_ring[i] = '0;

    rst      = 1'b1;
    in_valid = 1'b0;
    sample   = '0;
    wr_en    = 1'b0;
    wr_index = REG_TARGET;
    wr_data  = '0;

    // Directed rows, starting from the reset values target 0, deviation limit 0:
    //  - the largest sample alone: mean is the sample, off target
    //  - then the smallest: sum -1 over two truncates toward zero to 0
    //  - fill the rest of the window with the largest sample, then overwrite
    //    the oldest entries until all sixteen hold it: settled with no slack
    //  - widest limit with the lowest target, then mixed patterns
    dir_rows = '{
      '{ROW_SAMPLE, 16'h7FFF, 1,  1'b1, 16'sh7FFF, 1'b0, 1'b0},
      '{ROW_SAMPLE, 16'h8000, 1,  1'b1, 16'sh0000, 1'b0, 1'b1},
      '{ROW_LIMIT,  16'h0000, 1,  1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_TARGET, 16'h7FFF, 1,  1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_SAMPLE, 16'h7FFF, 14, 1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_SAMPLE, 16'h7FFF, 1,  1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_SAMPLE, 16'h7FFF, 1,  1'b1, 16'sh7FFF, 1'b1, 1'b1},
      '{ROW_TARGET, 16'h8000, 1,  1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_LIMIT,  16'hFFFF, 1,  1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_SAMPLE, 16'h8000, 1,  1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_SAMPLE, 16'h5555, 2,  1'b0, 16'sh0000, 1'b0, 1'b0},
      '{ROW_SAMPLE, 16'hAAAA, 2,  1'b0, 16'sh0000, 1'b0, 1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the table; registers are only touched once the block has drained.
    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_rows[i].kind)
        ROW_SAMPLE: begin
          typed_res.mean      = dir_rows[i].mean;
          typed_res.settled   = dir_rows[i].settled;
          typed_res.on_target = dir_rows[i].on_target;
          repeat (dir_rows[i].reps)
            send_sample(sample_t'(dir_rows[i].value), dir_rows[i].typed, typed_res);
        end
        ROW_TARGET: begin
          drain();
          write_reg(REG_TARGET, dir_rows[i].value);
        end
        default: begin
          drain();
          write_reg(REG_DEV_LIMIT, dir_rows[i].value);
        end
      endcase
    end

    // Random phases. Most are steady levels with small noise so that the
    // window fills and settles; two are dominated by full-range noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      level = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 4))
        0:       spread = 0;
        1:       spread = 2;
        2:       spread = 30;
        3:       spread = 400;
        default: spread = 6000;
      endcase
      noisy = (p == 2 || p == 6);

      if (p == 0) begin
        tgt = 16'h8000;
        lim = 16'hFFFF;
      end else if (p == 1) begin
        tgt = 16'h7FFF;
        lim = 16'h0000;
      end else begin
        case ($urandom_range(0, 4))
          0:       tgt = 16'h7FFF;
          1:       tgt = 16'h8000;
          2:       tgt = 16'($urandom_range(0, 65535));
          default: begin
            // aim near the level so that on_target goes both ways
            offset = level + int'($urandom_range(0, 64)) - 32;
            if (offset > 32767)  offset = 32767;
            if (offset < -32768) offset = -32768;
            tgt = 16'(offset);
          end
        endcase
        case ($urandom_range(0, 4))
          0:       lim = 16'h0000;
          1:       lim = 16'hFFFF;
          2:       lim = 16'($urandom_range(0, 16));
          3:       lim = 16'($urandom_range(16, 600));
          default: lim = 16'($urandom_range(0, 65535));
        endcase
      end
      write_reg(REG_TARGET, tgt);
      write_reg(REG_DEV_LIMIT, lim);
      burst = (p % 4 == 3);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // occasional step in the level, so the window has to settle again
        if ($urandom_range(0, 39) == 0)
          level = int'($urandom_range(0, 65535)) - 32768;
        send_sample(make_sample(level, spread, noisy), 1'b0, typed_res);
      end
    end

    burst = 1'b0;
    drain();

    $display("Sent %0d samples over %0d directed rows and %0d random phases; %0d results checked",
             samples_sent, DIR_ROWS, RANDOM_PHASES, results_checked);
    $display("Expected settled in %0d results, on target in %0d; %0d mismatches",
             settled_seen, on_target_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/masd_pkg.sv
hdl/masd_cell.sv
hdl/masd_div.sv
hdl/moving_average_settle_detector_top.sv
hdl/masd_checker.sv
test/testbench.sv
